// ----- hw/rtl/afs_pkg.sv -----
`timescale 1ns / 1ps

package afs_pkg;

  // One incoming stream byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } item_t;

  // One result.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_end;
    logic [12:0] frame_length;
    logic [1:0]  status;
  } res_t;

  // Result status codes.
  localparam logic [1:0] ST_FRAME      = 2'd0;
  localparam logic [1:0] ST_NO_FRAME   = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

  // Sync word and header fields.
  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE = 4'hF;
  localparam int          HEADER_BYTES = 6;
  localparam logic [12:0] MIN_LENGTH  = 13'd7;
  localparam logic [12:0] HEADER_LEN  = 13'd6;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_PASS
  } phase_e;

  // Main action of one queued command.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_BYTE,
    ACT_HEADER,
    ACT_BAD
  } act_e;

  // Work handed from the front to the back: a main action followed by an
  // optional buffer-end status result.
  typedef struct packed {
    act_e                  act;
    logic [5:0][7:0]       header;
    logic [7:0]            data;
    logic                  fe;
    logic [12:0]           len;
    logic                  tail;
    logic [1:0]            tail_status;
    logic [12:0]           tail_len;
  } cmd_t;

endpackage

// ----- hw/rtl/afs_front.sv -----
`timescale 1ns / 1ps

module afs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  afs_pkg::item_t item_i,
  input  logic           queue_full_i,
  output logic           cmd_push_o,
  output afs_pkg::cmd_t  cmd_o
);

  afs_pkg::phase_e  phase_q, phase_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [4:0][7:0]  store_q, store_d;
  logic [12:0]      remain_q, remain_d;
  logic [12:0]      held_q, held_d;

  always_comb begin
    logic [7:0]  b;
    logic [12:0] len;
    logic [12:0] rem;
    logic        ended;

    b        = item_i.in_byte;
    len      = {store_q[3][1:0], store_q[4], b[7:5]};
    rem      = remain_q;
    ended    = 1'b0;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    store_d  = store_q;
    remain_d = remain_q;
    held_d   = held_q;

    cmd_o             = '0;
    cmd_o.act         = afs_pkg::ACT_NONE;
    cmd_o.header      = {b, store_q};
    cmd_o.data        = b;
    cmd_o.len         = held_q;

    unique case (phase_q)
      afs_pkg::PH_HUNT: begin
        if (cnt_q == 3'd1 && b[7:4] == afs_pkg::SYNC_NIBBLE) begin
          store_d[1] = b;
          cnt_d      = 3'd2;
          held_d     = '0;
          phase_d    = afs_pkg::PH_HEAD;
        end else if (b == afs_pkg::SYNC_BYTE) begin
          store_d[0] = b;
          cnt_d      = 3'd1;
        end else begin
          cnt_d = 3'd0;
        end
      end
      afs_pkg::PH_HEAD: begin
        if (cnt_q == 3'(afs_pkg::HEADER_BYTES - 1)) begin
          cnt_d     = 3'd0;
          cmd_o.len = len;
          if (len < afs_pkg::MIN_LENGTH) begin
            cmd_o.act = afs_pkg::ACT_BAD;
            held_d    = '0;
            phase_d   = afs_pkg::PH_HUNT;
          end else begin
            cmd_o.act = afs_pkg::ACT_HEADER;
            held_d    = len;
            remain_d  = len - afs_pkg::HEADER_LEN;
            phase_d   = afs_pkg::PH_PASS;
          end
        end else begin
          store_d[cnt_q] = b;
          cnt_d          = cnt_q + 3'd1;
        end
      end
      afs_pkg::PH_PASS: begin
        if (remain_q != '0) begin
          rem = remain_q - 13'd1;
        end
        remain_d  = rem;
        cmd_o.act = afs_pkg::ACT_BYTE;
        cmd_o.fe  = (rem == '0);
        if (rem == '0) begin
          phase_d = afs_pkg::PH_HUNT;
          cnt_d   = 3'd0;
          ended   = 1'b1;
        end
      end
      default: begin
        phase_d = afs_pkg::PH_HUNT;
        cnt_d   = 3'd0;
      end
    endcase

    // Buffer end: report a missing or cut-short frame, then start hunting.
    if (item_i.buffer_end && !ended) begin
      cmd_o.tail = 1'b1;
      if (phase_d == afs_pkg::PH_HUNT) begin
        cmd_o.tail_status = afs_pkg::ST_NO_FRAME;
        cmd_o.tail_len    = '0;
      end else begin
        cmd_o.tail_status = afs_pkg::ST_INCOMPLETE;
        cmd_o.tail_len    = held_d;
      end
      phase_d  = afs_pkg::PH_HUNT;
      cnt_d    = 3'd0;
      remain_d = '0;
      held_d   = '0;
    end

    cmd_push_o = accept_i && (cmd_o.act != afs_pkg::ACT_NONE || cmd_o.tail);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= afs_pkg::PH_HUNT;
      cnt_q    <= 3'd0;
      remain_q <= '0;
      held_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      remain_q <= remain_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      store_q <= store_d;
    end
  end

  a_hunt_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == afs_pkg::PH_HUNT |-> cnt_q <= 3'd1)
    else $error("header count out of range while hunting");

  a_head_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == afs_pkg::PH_HEAD |-> cnt_q >= 3'd2 && cnt_q <= 3'd5)
    else $error("header count out of range while collecting");

  a_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == afs_pkg::PH_PASS |-> remain_q != '0 && held_q >= afs_pkg::MIN_LENGTH)
    else $error("payload phase without a valid frame length");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !queue_full_i)
    else $error("byte taken while the command queue is full");

endmodule

// ----- hw/rtl/afs_fifo.sv -----
`timescale 1ns / 1ps

module afs_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  afs_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output afs_pkg::cmd_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  afs_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

// ----- hw/rtl/afs_back.sv -----
`timescale 1ns / 1ps

module afs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  afs_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output afs_pkg::res_t res_o,
  output logic          empty_o,
  input  logic          pop_i
);

  logic [2:0]    idx_q;
  logic          out_valid_q;
  afs_pkg::res_t res_q, res_d;
  logic [2:0]    main_cnt, total;
  logic          load, last_res;

  always_comb begin
    unique case (cmd_i.act)
      afs_pkg::ACT_HEADER: main_cnt = 3'(afs_pkg::HEADER_BYTES);
      afs_pkg::ACT_BYTE,
      afs_pkg::ACT_BAD:    main_cnt = 3'd1;
      default:             main_cnt = 3'd0;
    endcase
    total = main_cnt + {2'b00, cmd_i.tail};

    res_d = '0;
    if (idx_q < main_cnt) begin
      unique case (cmd_i.act)
        afs_pkg::ACT_HEADER: begin
          res_d.out_byte     = cmd_i.header[idx_q];
          res_d.frame_length = cmd_i.len;
          res_d.status       = afs_pkg::ST_FRAME;
        end
        afs_pkg::ACT_BYTE: begin
          res_d.out_byte     = cmd_i.data;
          res_d.frame_end    = cmd_i.fe;
          res_d.frame_length = cmd_i.len;
          res_d.status       = afs_pkg::ST_FRAME;
        end
        afs_pkg::ACT_BAD: begin
          res_d.frame_length = cmd_i.len;
          res_d.status       = afs_pkg::ST_BAD_LENGTH;
        end
        default: res_d = '0;
      endcase
    end else begin
      res_d.frame_length = cmd_i.tail_len;
      res_d.status       = cmd_i.tail_status;
    end
  end

  assign load      = cmd_valid_i && (!out_valid_q || pop_i);
  assign last_res  = (idx_q == total - 3'd1);
  assign cmd_pop_o = load && last_res;
  assign empty_o   = !out_valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last_res ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> idx_q < total)
    else $error("result index beyond the command's result count");

  a_fe_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_end |-> res_q.status == afs_pkg::ST_FRAME)
    else $error("frame end marked on a status result");

endmodule

// ----- hw/rtl/adts_frame_sync_unit.sv -----
`timescale 1ns / 1ps

// ADTS frame synchronizer. Stream bytes enter through a queue-style port
// (push/full) and frame bytes leave through one (pop/empty). The front hunts
// for the sync word (0xFF, then a byte with high nibble 0xF), collects header
// bytes 0 to 5 and extracts the 13-bit frame length. Each byte becomes at
// most one command in a QueueDepth-entry command queue. The back expands each
// command into results through a one-entry output register. When the header
// completes, it gives the six header bytes in turn, or one status 3 result
// for a length below 7. After that it gives one result per payload byte,
// with frame_end on the last. When buffer_end closes the buffer anywhere but
// on a frame's final byte, a status result follows: 1 no frame, or
// 2 incomplete. Input is taken at one byte per cycle whenever the queue has
// room. Output runs at one result per cycle, set by the single back-end
// output register, while pop is asserted and commands are queued. The
// six-result header burst is absorbed by the queue. A byte's first result
// passes through the command queue and then the output register before it
// reaches the result ports.
module adts_frame_sync_unit #(
  parameter int QueueDepth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  afs_pkg::item_t item_i,
  input  logic           push,
  output logic           full,
  output afs_pkg::res_t  res_o,
  output logic           empty,
  input  logic           pop
);

  afs_pkg::cmd_t front_cmd, queue_cmd;
  logic          front_push, queue_full, queue_valid, queue_pop;
  logic          accept;

  // Transfer a byte whenever the command queue has room.
  assign full   = queue_full;
  assign accept = push && !queue_full;

  afs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item_i),
    .queue_full_i (queue_full),
    .cmd_push_o   (front_push),
    .cmd_o        (front_cmd)
  );

  afs_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  afs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .res_o       (res_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // Hold the head command until its last result is loaded.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_pop |-> queue_valid)
    else $error("command drained from an empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !queue_full)
    else $error("command pushed into a full queue");

  a_out_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(!empty) |-> $past(queue_valid))
    else $error("result appeared without a queued command");

endmodule
